// ===== design/ata_tfb_pkg.sv =====
// Package with the word types, codes and constants of the ATA task-file builder.
`default_nettype none
package ata_tfb_pkg;

  localparam int unsigned LBA_W   = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned LBA28_W = 28;

  // Reciprocal of 63 scaled by 2^34; exact quotient for every 28-bit dividend.
  localparam int unsigned  RECIP_SHIFT = 34;
  localparam int unsigned  RECIP_W     = 29;
  localparam logic [28:0]  RECIP63     = 29'd272696337;
  localparam int unsigned  QUOT_W      = 22;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DRIVE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOT_ATA  = 2'd3;

  localparam logic [1:0] MODE_CHS   = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;
  localparam logic [1:0] MODE_LBA48 = 2'd2;

  localparam logic [7:0] DEVHEAD_CHS = 8'hA0;
  localparam logic [7:0] DEVHEAD_LBA = 8'hE0;

  localparam logic [7:0] CMD_READ       = 8'h20;
  localparam logic [7:0] CMD_READ_EXT   = 8'h24;
  localparam logic [7:0] CMD_WRITE      = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT  = 8'h34;
  localparam logic [7:0] CMD_FLUSH      = 8'hE7;
  localparam logic [7:0] CMD_FLUSH_EXT  = 8'hEA;
  localparam logic [7:0] CMD_NONE       = 8'h00;

  typedef struct packed {
    logic              op;
    logic [LBA_W-1:0]  lba;
    logic [CNT_W-1:0]  sector_count;
    logic              device_bit;
    logic              lba_capable;
    logic [LBA_W-1:0]  disk_size;
    logic              drive_present;
    logic              drive_is_ata;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] mode;
    logic [7:0] device_head;
    logic [7:0] count_byte;
    logic [7:0] addr_byte0;
    logic [7:0] addr_byte1;
    logic [7:0] addr_byte2;
    logic [7:0] addr_byte3;
    logic [7:0] command;
    logic [7:0] flush_command;
  } res_t;

  typedef struct packed {
    logic [5:0]  sector;
    logic [3:0]  head;
    logic [15:0] cylinder;
  } chs_t;

endpackage
`default_nettype wire

// ===== design/ata_tfb_req_if.sv =====
// Request channel interface: valid, ready and one request word.
`default_nettype none
interface ata_tfb_req_if;
  import ata_tfb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ata_tfb_res_if.sv =====
// Result channel interface: valid, ready and one task-file word.
`default_nettype none
interface ata_tfb_res_if;
  import ata_tfb_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ata_tfb_chs.sv =====
// Splits a 28-bit sector address into CHS sector, head and cylinder.
`default_nettype none
module ata_tfb_chs (
  input  logic [ata_tfb_pkg::LBA28_W-1:0] lba28,
  output ata_tfb_pkg::chs_t               chs
);
  import ata_tfb_pkg::*;

  localparam int unsigned PROD_W = LBA28_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [5:0]        rem;

  // The track index is lba / 63; its low four bits are the head and bits 19:4
  // are the cylinder. The remainder only needs the low six bits of each term.
  assign prod = PROD_W'(lba28) * PROD_W'(RECIP63);
  assign quot = prod[RECIP_SHIFT +: QUOT_W];
  assign rem  = lba28[5:0] + quot[5:0];

  assign chs.sector   = rem + 6'd1;
  assign chs.head     = quot[3:0];
  assign chs.cylinder = quot[19:4];

endmodule
`default_nettype wire

// ===== design/ata_tfb_calc.sv =====
// Checks one request and builds its task-file word.
`default_nettype none
module ata_tfb_calc (
  input  ata_tfb_pkg::req_t req,
  output ata_tfb_pkg::res_t res
);
  import ata_tfb_pkg::*;

  logic [LBA_W:0] end_sector;
  logic           range_err;
  logic           use_lba48;
  chs_t           chs;
  logic [1:0]     mode;
  logic [7:0]     base;
  logic [3:0]     head;
  logic [7:0]     b0;
  logic [7:0]     b1;
  logic [7:0]     b2;
  logic [7:0]     b3;

  ata_tfb_chs u_chs (
    .lba28 (req.lba[LBA28_W-1:0]),
    .chs   (chs)
  );

  assign end_sector = {1'b0, req.lba} + (LBA_W+1)'(req.sector_count);
  assign range_err  = end_sector > {1'b0, req.disk_size};
  assign use_lba48  = |req.lba[LBA_W-1:LBA28_W];

  always_comb begin
    if (use_lba48) begin
      mode = MODE_LBA48;
      base = DEVHEAD_LBA;
      head = 4'd0;
      b0   = req.lba[7:0];
      b1   = req.lba[15:8];
      b2   = req.lba[23:16];
      b3   = req.lba[31:24];
    end else if (req.lba_capable) begin
      mode = MODE_LBA28;
      base = DEVHEAD_LBA;
      head = req.lba[27:24];
      b0   = req.lba[7:0];
      b1   = req.lba[15:8];
      b2   = req.lba[23:16];
      b3   = 8'd0;
    end else begin
      mode = MODE_CHS;
      base = DEVHEAD_CHS;
      head = chs.head;
      b0   = {2'b00, chs.sector};
      b1   = chs.cylinder[7:0];
      b2   = chs.cylinder[15:8];
      b3   = 8'd0;
    end
  end

  always_comb begin
    res = '0;
    if (!req.drive_present) begin
      res.status = ST_NO_DRIVE;
    end else if (!req.drive_is_ata) begin
      res.status = ST_NOT_ATA;
    end else if (range_err) begin
      res.status = ST_RANGE;
    end else begin
      res.status      = ST_OK;
      res.mode        = mode;
      res.device_head = base | {3'b000, req.device_bit, head};
      res.count_byte  = req.sector_count;
      res.addr_byte0  = b0;
      res.addr_byte1  = b1;
      res.addr_byte2  = b2;
      res.addr_byte3  = b3;
      if (req.op) begin
        res.command       = use_lba48 ? CMD_WRITE_EXT : CMD_WRITE;
        res.flush_command = use_lba48 ? CMD_FLUSH_EXT : CMD_FLUSH;
      end else begin
        res.command       = use_lba48 ? CMD_READ_EXT : CMD_READ;
        res.flush_command = CMD_NONE;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ata_taskfile_builder.sv =====
// Top level of the ATA task-file builder: request register, build logic, result register.
//
// A request word on in_req carries the direction, starting sector, sector count
// and the attributes of the addressed drive. For each accepted request exactly
// one result word appears on out_res, in order: a status code and, when the
// status is ok, the task-file bytes with the read or write opcode and, for a
// write, the cache-flush opcode. A word moves when valid and ready are both
// high at a rising edge of clk.
// The request is registered at the edge that accepts it, and the checks, the CHS
// split and the byte selection run in one pass from the request register into
// the result register. Throughput is one word per cycle while out_res does not
// stall; the longest path is the multiply by the reciprocal of 63 that gives
// the track index in CHS mode.
// When out_res stalls, the result register holds its word and one more request
// is still taken into the request register; in_req.ready falls only when both
// are full. A synchronous reset (rst_n low) empties both registers, so no
// result is valid after reset.
`default_nettype none
module ata_taskfile_builder (
  input  logic                 clk,
  input  logic                 rst_n,
  ata_tfb_req_if.sink          in_req,
  ata_tfb_res_if.source        out_res
);
  import ata_tfb_pkg::*;

  logic s1_vld_r;
  logic s1_vld_nxt;
  req_t s1_req_r;
  logic out_vld_r;
  logic out_vld_nxt;
  res_t out_res_r;
  res_t calc_res;
  logic in_acc;
  logic s2_adv;

  ata_tfb_calc u_calc (
    .req (s1_req_r),
    .res (calc_res)
  );

  assign s2_adv       = !out_vld_r || out_res.ready;
  assign in_req.ready = !s1_vld_r || s2_adv;
  assign in_acc       = in_req.valid && in_req.ready;

  assign s1_vld_nxt  = in_acc ? 1'b1 : (s2_adv ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s2_adv ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_req.data;
    end
    if (s2_adv) begin
      out_res_r <= calc_res;
    end
  end

  assign out_res.valid = out_vld_r;
  assign out_res.data  = out_res_r;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (s1_vld_r && out_vld_r))
    else $error("Request side stalled with a free register.");

  a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_res.ready) |=> s1_vld_r)
    else $error("Pending request dropped while the result was stalled.");

  a_error_no_command: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.data.status != ST_OK) |->
      (out_res.data.command == CMD_NONE && out_res.data.flush_command == CMD_NONE))
    else $error("Command issued with an error status.");

  a_lba48_ext_command: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.data.mode == MODE_LBA48) |->
      (out_res.data.command == CMD_READ_EXT || out_res.data.command == CMD_WRITE_EXT))
    else $error("LBA48 result without an extended command.");

endmodule
`default_nettype wire

// ===== bench/ata_taskfile_builder_test.sv =====
// Self-checking testbench of the ATA task-file builder with a task-file predictor and random stalls.
`timescale 1ns / 1ps
module ata_taskfile_builder_test;
  import ata_tfb_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;

  logic clk;
  logic rst_n;
  bit idle_en;
  int unsigned hold_cycles;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  res_t pending_taskfiles[$];

  ata_tfb_req_if req_ch();
  ata_tfb_res_if res_ch();

  ata_taskfile_builder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_ch),
    .out_res(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t build_taskfile(req_t r);
    res_t t;
    logic [32:0] span_end;
    logic [31:0] cyl;
    logic [31:0] hd;
    t = '0;
    span_end = {1'b0, r.lba} + {25'd0, r.sector_count};
    if (!r.drive_present) begin
      t.status = ST_NO_DRIVE;
    end else if (!r.drive_is_ata) begin
      t.status = ST_NOT_ATA;
    end else if (span_end > {1'b0, r.disk_size}) begin
      t.status = ST_RANGE;
    end else begin
      t.status = ST_OK;
      t.count_byte = r.sector_count;
      if (r.lba >= 32'h1000_0000) begin
        t.mode = MODE_LBA48;
        t.addr_byte0 = r.lba[7:0];
        t.addr_byte1 = r.lba[15:8];
        t.addr_byte2 = r.lba[23:16];
        t.addr_byte3 = r.lba[31:24];
        t.device_head = DEVHEAD_LBA | {3'b000, r.device_bit, 4'h0};
      end else if (r.lba_capable) begin
        t.mode = MODE_LBA28;
        t.addr_byte0 = r.lba[7:0];
        t.addr_byte1 = r.lba[15:8];
        t.addr_byte2 = r.lba[23:16];
        t.device_head = DEVHEAD_LBA | {3'b000, r.device_bit, r.lba[27:24]};
      end else begin
        // Sixteen heads of 63 sectors make one cylinder; the cylinder keeps 16 bits.
        cyl = r.lba / 32'd1008;
        hd = (r.lba % 32'd1008) / 32'd63;
        t.mode = MODE_CHS;
        t.addr_byte0 = 8'(r.lba % 32'd63 + 32'd1);
        t.addr_byte1 = cyl[7:0];
        t.addr_byte2 = cyl[15:8];
        t.device_head = DEVHEAD_CHS | {3'b000, r.device_bit, hd[3:0]};
      end
      if (r.op) begin
        t.command = (t.mode == MODE_LBA48) ? CMD_WRITE_EXT : CMD_WRITE;
        t.flush_command = (t.mode == MODE_LBA48) ? CMD_FLUSH_EXT : CMD_FLUSH;
      end else begin
        t.command = (t.mode == MODE_LBA48) ? CMD_READ_EXT : CMD_READ;
        t.flush_command = CMD_NONE;
      end
    end
    return t;
  endfunction

  function automatic req_t make_req(logic op, logic [31:0] lba, logic [7:0] cnt, logic dev,
                                    logic cap, logic [31:0] size, logic present, logic ata);
    req_t r;
    r.op = op;
    r.lba = lba;
    r.sector_count = cnt;
    r.device_bit = dev;
    r.lba_capable = cap;
    r.disk_size = size;
    r.drive_present = present;
    r.drive_is_ata = ata;
    return r;
  endfunction

  // Most requests fit the disk; the rest get a random disk size, and some a missing or non-ATA drive.
  function automatic req_t random_request();
    req_t r;
    int unsigned kind;
    logic [32:0] span_end;
    kind = $urandom_range(0, 99);
    r.op = 1'($urandom);
    r.device_bit = 1'($urandom);
    r.lba_capable = 1'($urandom);
    r.sector_count = 8'($urandom);
    case ($urandom_range(0, 3))
      0: r.lba = $urandom_range(0, 200000);
      1: r.lba = $urandom_range(0, 32'h0FFF_FFFF);
      2: r.lba = $urandom_range(32'h0FFF_FF00, 32'h1000_0100);
      default: r.lba = $urandom;
    endcase
    if (kind < 75) begin
      span_end = {1'b0, r.lba} + {25'd0, r.sector_count};
      if ($urandom_range(0, 3) != 0) span_end = span_end + 33'($urandom_range(0, 100000));
      r.disk_size = span_end[32] ? 32'hFFFF_FFFF : span_end[31:0];
    end else begin
      r.disk_size = $urandom;
    end
    r.drive_present = !(kind >= 80 && kind < 88);
    r.drive_is_ata = !(kind >= 88 && kind < 96);
    return r;
  endfunction

  task automatic send_request(req_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    pending_taskfiles.push_back(build_taskfile(r));
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      $display("%0t ns: %s expected %h, got %h", $time, name, exp_val, got_val);
    end
  endfunction

  always @(posedge clk) begin
    res_t exp_tf;
    res_t got_tf;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got_tf = res_ch.data;
      if (pending_taskfiles.size() == 0) begin
        mismatches++;
        $display("%0t ns: word with none expected, expected nothing, got %p", $time, got_tf);
      end else begin
        exp_tf = pending_taskfiles.pop_front();
        compare_field("status", 8'(exp_tf.status), 8'(got_tf.status));
        compare_field("mode", 8'(exp_tf.mode), 8'(got_tf.mode));
        compare_field("device_head", exp_tf.device_head, got_tf.device_head);
        compare_field("count_byte", exp_tf.count_byte, got_tf.count_byte);
        compare_field("addr_byte0", exp_tf.addr_byte0, got_tf.addr_byte0);
        compare_field("addr_byte1", exp_tf.addr_byte1, got_tf.addr_byte1);
        compare_field("addr_byte2", exp_tf.addr_byte2, got_tf.addr_byte2);
        compare_field("addr_byte3", exp_tf.addr_byte3, got_tf.addr_byte3);
        compare_field("command", exp_tf.command, got_tf.command);
        compare_field("flush_command", exp_tf.flush_command, got_tf.flush_command);
      end
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("ata_taskfile_builder_test NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_drive_errors();
    send_request(make_req(1'b0, 32'd10, 8'd4, 1'b0, 1'b1, 32'd5, 1'b0, 1'b0));
    send_request(make_req(1'b1, 32'd0, 8'd1, 1'b1, 1'b1, 32'd100, 1'b0, 1'b1));
    send_request(make_req(1'b1, 32'd90, 8'd20, 1'b0, 1'b0, 32'd100, 1'b1, 1'b0));
    send_request(make_req(1'b0, 32'd90, 8'd20, 1'b1, 1'b1, 32'd100, 1'b1, 1'b1));
  endtask

  task automatic test_addressing_modes();
    send_request(make_req(1'b0, 32'd0, 8'd1, 1'b0, 1'b0, 32'd1000, 1'b1, 1'b1));
    send_request(make_req(1'b1, 32'h0FFF_FFFF, 8'd0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'd12345, 8'd8, 1'b1, 1'b0, 32'd200000, 1'b1, 1'b1));
    send_request(make_req(1'b1, 32'h0FFF_FFFF, 8'd1, 1'b1, 1'b1, 32'h1000_0000, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'h0ABC_DEF0, 8'd16, 1'b0, 1'b1, 32'h0FFF_FFFF, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'h1000_0000, 8'd2, 1'b0, 1'b1, 32'h2000_0000, 1'b1, 1'b1));
    send_request(make_req(1'b1, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1));
  endtask

  task automatic test_range_limits();
    send_request(make_req(1'b1, 32'd1000, 8'd255, 1'b0, 1'b1, 32'd1255, 1'b1, 1'b1));
    send_request(make_req(1'b1, 32'd1001, 8'd255, 1'b0, 1'b1, 32'd1255, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'd0, 8'd1, 1'b0, 1'b1, 32'd0, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_request(make_req(1'b1, 32'hFFFF_FF00, 8'd255, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
  endtask

  task automatic test_random_requests(int unsigned n);
    repeat (n) send_request(random_request());
  endtask

  task automatic test_output_stall();
    // The sink holds off long enough for both internal registers to fill.
    hold_cycles = 60;
    repeat (40) send_request(random_request());
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (60) send_request(random_request());
  endtask

  initial begin
    int unsigned drain_wait;
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    idle_en = 1'b1;
    hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_drive_errors();
    test_addressing_modes();
    test_range_limits();
    test_random_requests(700);
    test_output_stall();
    test_back_to_back();
    req_ch.valid <= 1'b0;
    while (pending_taskfiles.size() != 0) @(posedge clk);
    drain_wait = 8;
    repeat (drain_wait) @(posedge clk);
    if (mismatches == 0 && pending_taskfiles.size() == 0) begin
      $display("ata_taskfile_builder_test OK");
    end else begin
      $display("ata_taskfile_builder_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ata_tfb_pkg.sv
design/ata_tfb_req_if.sv
design/ata_tfb_res_if.sv
design/ata_tfb_chs.sv
design/ata_tfb_calc.sv
design/ata_taskfile_builder.sv
bench/ata_taskfile_builder_test.sv
